/* rtl/guard_word_make_and_check_assert.svh */
// Assertion macros used by the guard word datapath.
`ifndef GUARD_WORD_MAKE_AND_CHECK_ASSERT_SVH
`define GUARD_WORD_MAKE_AND_CHECK_ASSERT_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define GWMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication from an antecedent to a consequent in the following cycle.
`define GWMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gwmc_pkg.sv */
`default_nettype none

package gwmc_pkg;

    localparam logic [1:0]  CMD_MAKE   = 2'd0;
    localparam logic [1:0]  CMD_CHECK  = 2'd1;
    localparam logic [1:0]  CMD_KILL   = 2'd2;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] SIGN_PRIME = 32'd1445174711;
    localparam logic [31:0] FAIR_HIGH  = 32'hFFFF0000;
    localparam logic [31:0] FAIR_LOW   = 32'h0000FFFF;
    localparam logic [63:0] POISON     = 64'h0000_000D_EADB_0D1F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;       // take the input item into the datapath
        logic iterate;    // step the generator and try the next seed
        logic capture;    // park the evaluated result in the hold register
        logic push;       // load the output register
        logic from_eval;  // push source: evaluated result, else hold register
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic [1:0] cmd;
        logic       fair_pair;
        logic       last_try;
        logic       out_free;
    } ctrl_stat_t;

    function automatic logic is_fair(input logic [31:0] v);
        return (v > FAIR_LOW) && (v < FAIR_HIGH);
    endfunction

endpackage

`default_nettype wire

/* rtl/guard_word_make_and_check.sv */
// Channel  Direction  tdata (low bit up)                           tuser
// s_*      in         seed[31:0] salt[63:32] guard_in[127:64]      command[1:0]
// m_*      out        guard_out[63:0]                              check_failed[0]
// cfg_*    in         cfg_wdata = checks_disabled, written when cfg_we is high
//
// Check and make pass through a multiply state and an evaluate state after accept;
// make repeats both for each extra generator step, since each seed tried goes through one
// registered multiply and one evaluation. Kill and the unused command go straight to hold.
// A new item is accepted the cycle after the previous result enters the output register.
// A finished result waits in a hold register while the output is stalled.
// Reset is asynchronous and active low and clears checks_disabled and all control state.
`default_nettype none

module guard_word_make_and_check
    import gwmc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // seed, salt, guard_in
    input  wire logic [1:0]   s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // guard_out
    output logic [0:0]        m_tuser    // check_failed
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    gwmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gwmc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

/* rtl/gwmc_ctrl.sv */
`default_nettype none

module gwmc_ctrl
    import gwmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    logic needs_mul;
    logic retry;

    assign needs_mul = (stat.in_cmd == CMD_MAKE) || (stat.in_cmd == CMD_CHECK);
    // Only make loops; it stops on a fair pair or after the full generator period.
    assign retry = (stat.cmd == CMD_MAKE) && !stat.fair_pair && !stat.last_try;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = needs_mul ? ST_MUL : ST_HOLD;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                priority if (retry)
                begin
                    state_next = ST_MUL;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:
            begin
            end
            ST_EVAL:
            begin
                priority if (retry)
                begin
                    cmd.iterate = 1'b1;
                end
                else if (stat.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.from_eval = 1'b1;
                end
                else
                begin
                    cmd.capture = 1'b1;
                end
            end
            ST_HOLD:
            begin
                cmd.push = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/gwmc_datapath.sv */
`default_nettype none

`include "guard_word_make_and_check_assert.svh"

module gwmc_datapath
    import gwmc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic [127:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic [0:0]        m_tuser,
    input  wire ctrl_cmd_t    cmd,
    output ctrl_stat_t        stat
);

    logic        checks_disabled_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] x_reg;
    logic [31:0] salt_reg;
    logic [31:0] hi_reg;
    logic [31:0] sum_reg;
    logic [31:0] next_reg;
    logic [63:0] prod_reg;
    logic [31:0] tries_reg;
    logic [63:0] res_data_reg;
    logic        res_fail_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_data_reg;
    logic        m_fail_reg;

    logic [31:0] in_seed;
    logic [31:0] in_salt;
    logic [63:0] in_guard;
    logic [31:0] x_load;
    logic [31:0] sig;
    logic        fair_pair;
    logic        check_ok;
    logic [63:0] eval_data;
    logic        eval_fail;
    logic [31:0] lcg_prod;

    assign in_seed  = s_tdata[31:0];
    assign in_salt  = s_tdata[63:32];
    assign in_guard = s_tdata[127:64];
    // Check runs the signature on the seed half of the stored word.
    assign x_load   = (s_tuser == CMD_CHECK) ? in_guard[31:0] : in_seed;

    assign sig       = prod_reg[31:0] ^ prod_reg[63:32];
    assign fair_pair = is_fair(x_reg) && is_fair(sig);
    assign check_ok  = is_fair(x_reg) && is_fair(hi_reg) && (hi_reg == sig);
    assign lcg_prod  = x_reg * LCG_MUL;

    always_comb
    begin
        eval_data = 64'd0;
        eval_fail = 1'b0;
        if (cmd_reg == CMD_MAKE)
        begin
            eval_data = fair_pair ? {sig, x_reg} : POISON;
        end
        else
        begin
            eval_fail = !checks_disabled_reg && !check_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checks_disabled_reg <= 1'b0;
            m_tvalid_reg        <= 1'b0;
            cmd_reg             <= CMD_MAKE;
            tries_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                checks_disabled_reg <= cfg_wdata;
            end
            if (cmd.push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                cmd_reg   <= s_tuser;
                tries_reg <= '0;
            end
            else if (cmd.iterate)
            begin
                tries_reg <= tries_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, sum_reg} * {32'd0, SIGN_PRIME};
        next_reg <= lcg_prod + LCG_ADD;
        if (cmd.load)
        begin
            x_reg        <= x_load;
            salt_reg     <= in_salt;
            hi_reg       <= in_guard[63:32];
            sum_reg      <= x_load + in_salt;
            res_data_reg <= (s_tuser == CMD_KILL) ? POISON : 64'd0;
            res_fail_reg <= 1'b0;
        end
        else if (cmd.iterate)
        begin
            x_reg   <= next_reg;
            sum_reg <= next_reg + salt_reg;
        end
        if (cmd.capture)
        begin
            res_data_reg <= eval_data;
            res_fail_reg <= eval_fail;
        end
        if (cmd.push)
        begin
            m_data_reg <= cmd.from_eval ? eval_data : res_data_reg;
            m_fail_reg <= cmd.from_eval ? eval_fail : res_fail_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_fail_reg;

    assign stat.in_cmd    = s_tuser;
    assign stat.cmd       = cmd_reg;
    assign stat.fair_pair = fair_pair;
    assign stat.last_try  = &tries_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    `GWMC_ASSERT(a_no_overwrite, clk, rst_n, !(m_tvalid_reg && !m_tready && cmd.push), "result overwritten while output stalled")
    `GWMC_ASSERT(a_iter_make_only, clk, rst_n, !cmd.iterate || (cmd_reg == CMD_MAKE), "generator stepped for a command other than make")
    `GWMC_ASSERT(a_excl_cmds, clk, rst_n, !(cmd.load && (cmd.iterate || cmd.push || cmd.capture)), "load overlaps another datapath command")
    `GWMC_ASSERT_NEXT(a_push_valid, clk, rst_n, cmd.push, m_tvalid_reg, "pushed result not presented")

endmodule

`default_nettype wire
